FILE: rtl/qvr_pkg.sv
`timescale 1ns / 1ps
// qvr_pkg: shared widths, types and constants for the quaternion vector rotator
// no dependencies; imported by qvr_round_sat, quaternion_vector_rotate and quaternion_vector_rotate_tb
package qvr_pkg;

    localparam int SAMP_W     = 16;                 // every payload field
    localparam int PROD_W     = 2 * SAMP_W;         // 16 x 16 product
    localparam int SUM_W      = PROD_W + 1;         // sum of up to four products
    localparam int TERM_W     = SUM_W + SAMP_W - 1; // 33 x 16 product
    localparam int ACC_W      = TERM_W + 3;         // three terms, two doubled, plus bias
    localparam int FRAC_SHIFT = 2 * (SAMP_W - 1);   // two q1.15 factors
    localparam int QUO_W      = ACC_W - FRAC_SHIFT;
    localparam int N_AXES     = 3;
    localparam int N_QUAT     = 4;
    localparam int STAGES     = 5;

    localparam int IN_DATA_W  = 7 * SAMP_W;
    localparam int OUT_DATA_W = 3 * SAMP_W;

    // quaternion component positions
    localparam int QX = 0;
    localparam int QY = 1;
    localparam int QZ = 2;
    localparam int QW = 3;

    typedef logic signed [SAMP_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam acc_t    ROUND_BIAS = acc_t'(1) <<< (FRAC_SHIFT - 1);
    localparam sample_t SAT_POS    = {1'b0, {(SAMP_W-1){1'b1}}};
    localparam sample_t SAT_NEG    = {1'b1, {(SAMP_W-1){1'b0}}};

endpackage

FILE: rtl/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// quaternion_vector_rotate: top level, rotates a vector by q * v * conj(q)
// depends on qvr_pkg and qvr_round_sat
//
// usage
//   s_ channel: one beat carries a quaternion (q1.15) and a 16-bit vector
//   m_ channel: one beat carries the rotated vector and a clip flag in tuser
//   r = (w^2 - |u|^2) v + 2 (u . v) u + 2 w (u x v), formed exactly, then
//   rounded half up by 2^30 and clamped to 16 bits; a non-unit quaternion
//   scales the result by its squared norm
// pipeline
//   five register stages: 16x16 products, sums, 33x16 products, term
//   accumulation with rounding bias, round and clamp into the output register
//   an input beat passes through every stage register in turn before m_tvalid
//   throughput is one beat per cycle while m_tready stays high
// flow control
//   each stage holds its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up and s_tready stays high while
//   any stage is free, even with a result waiting on m_tready
//   a stalled output holds its beat; nothing is dropped or repeated
// reset
//   aresetn low clears all valid bits; payload registers are not reset
module quaternion_vector_rotate (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z
    input  logic [qvr_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // rot_x, rot_y, rot_z
    output logic [qvr_pkg::OUT_DATA_W-1:0] m_tdata,
    // saturated
    output logic [0:0]                     m_tuser
);
    import qvr_pkg::*;

    // ---------------------------------------------------------------- control
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] rdy;
    logic              s_fire;
    logic              m_fire;

    // stage k may load when empty or when its contents move on
    always_comb begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = vld_reg[STAGES-1];
    assign m_fire   = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------- input unpack
    sample_t in_q [N_QUAT];
    sample_t in_v [N_AXES];

    always_comb begin
        for (int i = 0; i < N_QUAT; i++) begin
            in_q[i] = sample_t'(s_tdata[i*SAMP_W +: SAMP_W]);
        end
        for (int i = 0; i < N_AXES; i++) begin
            in_v[i] = sample_t'(s_tdata[(N_QUAT+i)*SAMP_W +: SAMP_W]);
        end
    end

    // --------------------------------------------------- stage 0: 16x16 products
    prod_t   sq_next    [N_QUAT];
    prod_t   dot_next   [N_AXES];
    prod_t   cra_next   [N_AXES];
    prod_t   crb_next   [N_AXES];
    prod_t   sq_reg     [N_QUAT];
    prod_t   dot_reg    [N_AXES];
    prod_t   cra_reg    [N_AXES];
    prod_t   crb_reg    [N_AXES];
    sample_t q0_reg     [N_QUAT];
    sample_t v0_reg     [N_AXES];

    always_comb begin
        for (int i = 0; i < N_QUAT; i++) begin
            sq_next[i] = in_q[i] * in_q[i];
        end
        for (int i = 0; i < N_AXES; i++) begin
            dot_next[i] = in_q[i] * in_v[i];
        end
        // cross product u x v, each component as a minus b
        cra_next[0] = in_q[QY] * in_v[2];
        crb_next[0] = in_q[QZ] * in_v[1];
        cra_next[1] = in_q[QZ] * in_v[0];
        crb_next[1] = in_q[QX] * in_v[2];
        cra_next[2] = in_q[QX] * in_v[1];
        crb_next[2] = in_q[QY] * in_v[0];
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            sq_reg  <= sq_next;
            dot_reg <= dot_next;
            cra_reg <= cra_next;
            crb_reg <= crb_next;
            q0_reg  <= in_q;
            v0_reg  <= in_v;
        end
    end

    // ------------------------------------------------------------ stage 1: sums
    sum_t    s_next;
    sum_t    d_next;
    sum_t    c_next  [N_AXES];
    sum_t    s_reg;
    sum_t    d_reg;
    sum_t    c_reg   [N_AXES];
    sample_t q1_reg  [N_QUAT];
    sample_t v1_reg  [N_AXES];

    always_comb begin
        s_next = sum_t'(sq_reg[QW]) - sum_t'(sq_reg[QX])
               - sum_t'(sq_reg[QY]) - sum_t'(sq_reg[QZ]);
        d_next = sum_t'(dot_reg[0]) + sum_t'(dot_reg[1]) + sum_t'(dot_reg[2]);
        for (int i = 0; i < N_AXES; i++) begin
            c_next[i] = sum_t'(cra_reg[i]) - sum_t'(crb_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            s_reg  <= s_next;
            d_reg  <= d_next;
            c_reg  <= c_next;
            q1_reg <= q0_reg;
            v1_reg <= v0_reg;
        end
    end

    // --------------------------------------------------- stage 2: 33x16 products
    term_t ts_next [N_AXES];
    term_t td_next [N_AXES];
    term_t tc_next [N_AXES];
    term_t ts_reg  [N_AXES];
    term_t td_reg  [N_AXES];
    term_t tc_reg  [N_AXES];

    always_comb begin
        for (int i = 0; i < N_AXES; i++) begin
            ts_next[i] = s_reg * v1_reg[i];
            td_next[i] = d_reg * q1_reg[i];
            tc_next[i] = c_reg[i] * q1_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            ts_reg <= ts_next;
            td_reg <= td_next;
            tc_reg <= tc_next;
        end
    end

    // ------------------------------------------- stage 3: accumulate with bias
    acc_t acc_next [N_AXES];
    acc_t acc_reg  [N_AXES];

    always_comb begin
        for (int i = 0; i < N_AXES; i++) begin
            acc_next[i] = acc_t'(ts_reg[i]) + (acc_t'(td_reg[i]) <<< 1)
                        + (acc_t'(tc_reg[i]) <<< 1) + ROUND_BIAS;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            acc_reg <= acc_next;
        end
    end

    // -------------------------------------- stage 4: round, clamp, output beat
    sample_t          rot_next  [N_AXES];
    logic [N_AXES-1:0] clip_next;
    sample_t          rot_reg   [N_AXES];
    logic             sat_reg;

    for (genvar g = 0; g < N_AXES; g++) begin : g_round
        qvr_round_sat u_round_sat (
            .acc     (acc_reg[g]),
            .rot     (rot_next[g]),
            .clipped (clip_next[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            rot_reg <= rot_next;
            sat_reg <= |clip_next;
        end
    end

    always_comb begin
        for (int i = 0; i < N_AXES; i++) begin
            m_tdata[i*SAMP_W +: SAMP_W] = rot_reg[i];
        end
    end

    assign m_tuser[0] = sat_reg;

    // ------------------------------------------------------------- assertions
    // an empty first stage always takes a beat
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[0] |-> s_tready)
        else $error("s_tready low with an empty first stage");

    // occupancy changes only by accepted and delivered beats
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
        ($countones(vld_reg) == $countones($past(vld_reg))
                               + int'($past(s_fire)) - int'($past(m_fire))))
        else $error("pipeline lost or invented a beat");

    // the accumulator stage, blocked by its successor, keeps its beat and data
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] && !rdy[4] |=> vld_reg[3] && $stable(acc_reg[0]))
        else $error("stalled accumulator stage changed");

    // with every stage full and the output stalled, the whole chain is blocked
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg) && !m_tready |-> !s_tready)
        else $error("full pipeline accepted a beat under stall");

endmodule

FILE: rtl/qvr_round_sat.sv
`timescale 1ns / 1ps
// qvr_round_sat: scale a biased accumulator down by 2^30 and clamp to 16 bits
// depends on qvr_pkg
module qvr_round_sat (
    input  qvr_pkg::acc_t    acc,      // already holds the half-lsb rounding bias
    output qvr_pkg::sample_t rot,
    output logic             clipped
);
    import qvr_pkg::*;

    logic [QUO_W-1:0] quo;
    logic             sign;
    logic             any_hi;
    logic             all_hi;
    logic             over_pos;
    logic             over_neg;

    // arithmetic shift is a floor, so bias plus shift rounds half up
    assign quo      = acc[ACC_W-1:FRAC_SHIFT];
    assign sign     = quo[QUO_W-1];
    assign any_hi   = |quo[QUO_W-2:SAMP_W-1];
    assign all_hi   = &quo[QUO_W-2:SAMP_W-1];
    assign over_pos = !sign && any_hi;
    assign over_neg = sign && !all_hi;

    always_comb begin
        priority if (over_pos) begin
            rot = SAT_POS;
        end else if (over_neg) begin
            rot = SAT_NEG;
        end else begin
            rot = sample_t'(quo[SAMP_W-1:0]);
        end
    end

    assign clipped = over_pos || over_neg;

endmodule

FILE: test/quaternion_vector_rotate_tb.sv
`timescale 1ns / 1ps
// quaternion_vector_rotate_tb: self-checking bench for the quaternion vector rotator
// depends on qvr_pkg and quaternion_vector_rotate; a scoreboard class predicts each beat
module quaternion_vector_rotate_tb;
    import qvr_pkg::*;

    localparam int  N_RANDOM     = 950;
    localparam int  HOLD_CYCLES  = 250;       // long receiver hold-off, fills the pipeline
    localparam int  BURST_ITEMS  = 40;        // back-to-back beats offered during the hold-off
    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 2 * STAGES + 10;

    typedef logic [IN_DATA_W-1:0]  in_beat_t;
    typedef logic [OUT_DATA_W-1:0] out_beat_t;

    // one predicted output beat
    typedef struct {
        sample_t rot_x;
        sample_t rot_y;
        sample_t rot_z;
        logic    clipped;
    } rotation_t;

    // predicts q * v * conj(q) for each accepted input beat and checks the output beats
    class rotation_scoreboard;
        rotation_t expected_q[$];
        int        errors = 0;

        static function longint field(in_beat_t beat, int idx);
            return longint'($signed(beat[idx*SAMP_W +: SAMP_W]));
        endfunction

        // round half up by 2^30 then clamp to 16 bits
        static function sample_t round_clamp(longint acc, ref logic clipped);
            longint q;
            q = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
            if (q > 32767) begin
                clipped = 1'b1;
                return SAT_POS;
            end else if (q < -32768) begin
                clipped = 1'b1;
                return SAT_NEG;
            end
            return sample_t'(q);
        endfunction

        function rotation_t rotate(in_beat_t beat);
            longint qx, qy, qz, qw, vx, vy, vz;
            longint s, d, cx, cy, cz;
            rotation_t r;
            logic clipped;
            qx = field(beat, 0);
            qy = field(beat, 1);
            qz = field(beat, 2);
            qw = field(beat, 3);
            vx = field(beat, 4);
            vy = field(beat, 5);
            vz = field(beat, 6);
            // r = (w^2 - |u|^2) v + 2 (u . v) u + 2 w (u x v)
            s  = qw * qw - qx * qx - qy * qy - qz * qz;
            d  = qx * vx + qy * vy + qz * vz;
            cx = qy * vz - qz * vy;
            cy = qz * vx - qx * vz;
            cz = qx * vy - qy * vx;
            clipped = 1'b0;
            r.rot_x = round_clamp(s * vx + 2 * d * qx + 2 * qw * cx, clipped);
            r.rot_y = round_clamp(s * vy + 2 * d * qy + 2 * qw * cy, clipped);
            r.rot_z = round_clamp(s * vz + 2 * d * qz + 2 * qw * cz, clipped);
            r.clipped = clipped;
            return r;
        endfunction

        function void note_input(in_beat_t beat);
            expected_q.push_back(rotate(beat));
        endfunction

        function void check_result(out_beat_t data, logic clipped);
            rotation_t exp_r;
            sample_t   got_x, got_y, got_z;
            if (expected_q.size() == 0) begin
                $display("%0t: output beat with nothing expected, tdata %h tuser %b",
                         $time, data, clipped);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            got_x = data[0*SAMP_W +: SAMP_W];
            got_y = data[1*SAMP_W +: SAMP_W];
            got_z = data[2*SAMP_W +: SAMP_W];
            if (got_x !== exp_r.rot_x) begin
                $display("%0t: rot_x expected %0d actual %0d", $time, exp_r.rot_x, got_x);
                errors++;
            end
            if (got_y !== exp_r.rot_y) begin
                $display("%0t: rot_y expected %0d actual %0d", $time, exp_r.rot_y, got_y);
                errors++;
            end
            if (got_z !== exp_r.rot_z) begin
                $display("%0t: rot_z expected %0d actual %0d", $time, exp_r.rot_z, got_z);
                errors++;
            end
            if (clipped !== exp_r.clipped) begin
                $display("%0t: saturated expected %b actual %b", $time, exp_r.clipped,
                         clipped);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    bit        aclk;
    logic      aresetn;
    logic      s_tvalid;
    logic      s_tready;
    in_beat_t  s_tdata;     // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z
    logic      m_tvalid;
    logic      m_tready;
    out_beat_t m_tdata;     // rot_x, rot_y, rot_z
    logic [0:0] m_tuser;    // saturated

    rotation_scoreboard sb;
    int  cycle_count;
    bit  hold_request;      // set by the stimulus, taken up by the receiver
    bit  hold_done;         // the receiver has served the hold-off
    bit  steady_run;        // no new gaps or stalls start while this is set
    int  hold_left;
    int  stall_left;

    quaternion_vector_rotate u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock, 10 ns period
    always #5 aclk = ~aclk;

    // run limit, counts from the start of reset
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("** quaternion_vector_rotate: FAILED **");
            $finish;
        end
    end

    // note every accepted input beat and check every accepted output beat
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_input(s_tdata);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser[0]);
        end
    end

    // receiver: random stalls, some of them long, one long hold-off on request, and none started in a steady run
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (steady_run) begin
            m_tready <= 1'b1;
        end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 2) begin
                stall_left = $urandom_range(10, 40);
                m_tready <= 1'b0;
            end else begin
                m_tready <= (r >= 30);
            end
        end
    end

    function automatic in_beat_t pack_beat(int qx, int qy, int qz, int qw,
                                           int vx, int vy, int vz);
        return {vz[15:0], vy[15:0], vx[15:0], qw[15:0], qz[15:0], qy[15:0], qx[15:0]};
    endfunction

    // a quaternion close to unit norm, with a random axis and angle
    function automatic logic [4*SAMP_W-1:0] unit_quat();
        int  raw [4];
        int  c;
        real sumsq;
        real norm;
        logic [4*SAMP_W-1:0] q;
        sumsq = 0.0;
        for (int i = 0; i < 4; i++) begin
            raw[i] = int'($urandom_range(0, 65534)) - 32767;
            sumsq += real'(raw[i]) * real'(raw[i]);
        end
        norm = $sqrt(sumsq);
        if (norm < 1.0) begin
            return {16'sh7FFF, 48'h0};
        end
        for (int i = 0; i < 4; i++) begin
            c = $rtoi(real'(raw[i]) * 32767.0 / norm);
            q[i*SAMP_W +: SAMP_W] = c[15:0];
        end
        return q;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_run) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // offer one beat after an idle gap and wait until it is taken
    task automatic send_beat(in_beat_t beat, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random(int n, bit burst);
        in_beat_t beat;
        int mode;
        int vx, vy, vz;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 99);
            beat[IN_DATA_W-1:4*SAMP_W] = {16'($urandom_range(0, 65535)),
                                          16'($urandom_range(0, 65535)),
                                          16'($urandom_range(0, 65535))};
            if (mode < 70) begin
                // well-formed rotation, full-range vector
                beat[4*SAMP_W-1:0] = unit_quat();
            end else if (mode < 85) begin
                // arbitrary quaternion on a small vector, mostly unclipped
                beat[4*SAMP_W-1:0] = {$urandom, $urandom};
                vx = int'($urandom_range(0, 400)) - 200;
                vy = int'($urandom_range(0, 400)) - 200;
                vz = int'($urandom_range(0, 400)) - 200;
                beat[IN_DATA_W-1:4*SAMP_W] = {vz[15:0], vy[15:0], vx[15:0]};
            end else begin
                // raw bits everywhere
                beat[4*SAMP_W-1:0] = {$urandom, $urandom};
            end
            send_beat(beat, burst ? 0 : pick_gap());
        end
    endtask

    initial begin
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        aresetn      = 1'b0;
        steady_run   = 1'b0;
        sb = new();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed beats
        // zero quaternion gives all zeros, no clip
        send_beat(pack_beat(0, 0, 0, 0, 0, 0, 0), 0);
        send_beat(pack_beat(0, 0, 0, 0, 32767, -32768, 1), 0);
        // identity, both signs of w, extreme vector
        send_beat(pack_beat(0, 0, 0, 32767, 32767, -32768, 12345), pick_gap());
        send_beat(pack_beat(0, 0, 0, -32768, 32767, -32768, -1), 0);
        // half turns about each axis with a component of exactly -1.0, and one about x at +32767
        send_beat(pack_beat(-32768, 0, 0, 0, 1000, 2000, -3000), 0);
        send_beat(pack_beat(0, -32768, 0, 0, 1000, 2000, -3000), pick_gap());
        send_beat(pack_beat(0, 0, -32768, 0, 1000, 2000, -3000), 0);
        send_beat(pack_beat(32767, 0, 0, 0, -32768, 32767, 0), 0);
        // quarter turns about z, x and y
        send_beat(pack_beat(0, 0, 23170, 23170, 32767, 0, 0), 0);
        send_beat(pack_beat(23170, 0, 0, 23170, 0, 32767, -32768), pick_gap());
        send_beat(pack_beat(0, 23170, 0, 23170, -32768, 0, 32767), 0);
        // far from unit norm, clips hard
        send_beat(pack_beat(-32768, -32768, -32768, -32768, 32767, 32767, 32767), 0);
        send_beat(pack_beat(32767, 32767, 32767, 32767, -32768, -32768, -32768), 0);
        // squared norm near four on a small vector, scaled up without clipping
        send_beat(pack_beat(32767, 32767, 32767, 32767, 100, -200, 300), 0);
        // tiny tilt of the identity
        send_beat(pack_beat(1, -1, 1, 32767, -32768, 32767, -32768), pick_gap());
        // squared norm of a quarter: halves round up, negative halves round towards zero
        send_beat(pack_beat(0, 0, 0, 16384, 2, -2, 1), 0);
        send_beat(pack_beat(0, 0, 0, 16384, -6, 6, -1), 0);
        // -1.0 components on a zero vector
        send_beat(pack_beat(-32768, -32768, -32768, -32768, 0, 0, 0), 0);
        // alternating bit patterns
        send_beat({7{16'hAAAA}}, 0);
        send_beat({7{16'h5555}}, 0);
        send_beat({7{16'hFFFF}}, pick_gap());

        // random part, with a long hold-off and a stretch with no idling
        send_random(120, 1'b0);
        hold_request = 1'b1;
        send_random(BURST_ITEMS, 1'b1);
        send_random(300, 1'b0);
        steady_run = 1'b1;
        send_random(150, 1'b0);
        steady_run = 1'b0;
        send_random(N_RANDOM - 120 - BURST_ITEMS - 300 - 150, 1'b0);
        s_tvalid <= 1'b0;

        // drain
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("** quaternion_vector_rotate: PASSED **");
        end else begin
            $display("** quaternion_vector_rotate: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/qvr_pkg.sv
rtl/qvr_round_sat.sv
rtl/quaternion_vector_rotate.sv
test/quaternion_vector_rotate_tb.sv
